// File: hw/rtl/ibst_pkg.sv
package ibst_pkg;

    localparam int LEVELS     = 6;
    localparam int VALUE_BITS = 32;
    localparam int CAPACITY   = (1 << LEVELS) - 1;
    localparam int IDX_W      = LEVELS;
    localparam int WALK_W     = LEVELS + 1;
    localparam int SP_W       = $clog2(LEVELS + 1);
    localparam int STK_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int DATA_W     = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_SEARCH = 3'd1,
        OP_IN     = 3'd2,
        OP_PRE    = 3'd3,
        OP_POST   = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED   = 3'd0,
        ST_NO_ROOM    = 3'd1,
        ST_FOUND      = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_EMPTY      = 3'd4,
        ST_NODE       = 3'd5,
        ST_TRAV_EMPTY = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        PH_PRE  = 2'd0,
        PH_IN   = 2'd1,
        PH_POST = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_TRAV,
        S_TRAV_EX,
        S_FLUSH,
        S_EMPTY
    } state_t;

endpackage

// File: hw/rtl/implicit_array_bst_engine_core.sv
// Binary search tree held in heap order (children of node i at 2i+1 and 2i+2) in a
// 63-entry value memory with one synchronous read port, plus a valid flag per slot.
// s_tuser carries the operation, s_tdata the value; each result carries its status in
// m_tuser, the node value in m_tdata and the end of the results of one input transaction
// in m_tlast. Only one input transaction is processed at a time, and the next one is taken
// in the cycle after the last result has entered the output register. Insert and search
// visit one slot per step from the root: up to 6 slots while the walk stays inside the
// tree, and one more step when it goes past the bottom level. A traversal handles each
// stored node in three visit phases on the walk stack plus one memory read for the
// emitted value; an empty traversal gives one result with status traversal-empty.
// A stalled result output holds up all of these.
// Op codes five to seven are accepted and give no result.
module implicit_array_bst_engine_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ibst_pkg::DATA_W-1:0]     s_tdata,  // value
    input  logic [ibst_pkg::OP_W-1:0]       s_tuser,  // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ibst_pkg::DATA_W-1:0]     m_tdata,  // node_value
    output logic [ibst_pkg::STATUS_W-1:0]   m_tuser,  // status
    output logic                            m_tlast
);

    ibst_pkg::state_t state_reg, state_next;
    ibst_pkg::op_t    op_reg, op_next;
    ibst_pkg::phase_t order_reg, order_next;
    logic [ibst_pkg::VALUE_BITS-1:0] key_reg, key_next;
    logic [ibst_pkg::WALK_W-1:0]     idx_reg, idx_next;
    logic [ibst_pkg::SP_W-1:0]       sp_reg, sp_next;
    logic [ibst_pkg::IDX_W-1:0]      stk_idx_reg [ibst_pkg::LEVELS];
    logic [ibst_pkg::IDX_W-1:0]      stk_idx_next [ibst_pkg::LEVELS];
    ibst_pkg::phase_t                stk_ph_reg [ibst_pkg::LEVELS];
    ibst_pkg::phase_t                stk_ph_next [ibst_pkg::LEVELS];
    logic                            pend_valid_reg, pend_valid_next;
    logic [ibst_pkg::VALUE_BITS-1:0] pend_value_reg, pend_value_next;
    logic                            out_valid_reg, out_valid_next;
    ibst_pkg::status_t               out_status_reg, out_status_next;
    logic [ibst_pkg::VALUE_BITS-1:0] out_value_reg, out_value_next;
    logic                            out_last_reg, out_last_next;
    logic [ibst_pkg::CAPACITY-1:0]   valid_reg, valid_next;

    logic [ibst_pkg::VALUE_BITS-1:0] mem [ibst_pkg::CAPACITY];
    logic [ibst_pkg::VALUE_BITS-1:0] rd_data_reg;
    logic [ibst_pkg::IDX_W-1:0]      rd_addr;
    logic                            mem_we;

    logic                            s_accept;
    logic                            out_free;
    logic                            walk_in;
    logic                            walk_gt;
    logic                            walk_eq;
    logic                            walk_done;
    logic [ibst_pkg::WALK_W-1:0]     walk_child;
    logic [ibst_pkg::STK_W-1:0]      top_pos;
    logic [ibst_pkg::IDX_W-1:0]      top_idx;
    ibst_pkg::phase_t                top_ph;
    logic [ibst_pkg::WALK_W-1:0]     trav_child;
    logic                            trav_push;
    ibst_pkg::op_t                   s_op;

    assign s_op     = ibst_pkg::op_t'(s_tuser);
    assign s_tready = (state_reg == ibst_pkg::S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign walk_in   = (idx_reg < ibst_pkg::WALK_W'(ibst_pkg::CAPACITY))
                       && valid_reg[idx_reg[ibst_pkg::IDX_W-1:0]];
    assign walk_gt   = $signed(rd_data_reg) > $signed(key_reg);
    assign walk_eq   = (rd_data_reg == key_reg);
    assign walk_done = !walk_in || ((op_reg == ibst_pkg::OP_SEARCH) && walk_eq);
    assign walk_child = {idx_reg[ibst_pkg::IDX_W-1:0], 1'b0}
                        + (walk_gt ? ibst_pkg::WALK_W'(1) : ibst_pkg::WALK_W'(2));

    assign top_pos    = ibst_pkg::STK_W'(sp_reg - ibst_pkg::SP_W'(1));
    assign top_idx    = stk_idx_reg[top_pos];
    assign top_ph     = stk_ph_reg[top_pos];
    assign trav_child = {top_idx, 1'b0} + ibst_pkg::WALK_W'(1)
                        + ibst_pkg::WALK_W'(top_ph);
    assign trav_push  = (trav_child < ibst_pkg::WALK_W'(ibst_pkg::CAPACITY))
                        && valid_reg[trav_child[ibst_pkg::IDX_W-1:0]]
                        && (sp_reg < ibst_pkg::SP_W'(ibst_pkg::LEVELS));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ibst_pkg::S_IDLE: begin
                if (s_accept) begin
                    priority if (s_op == ibst_pkg::OP_INSERT || s_op == ibst_pkg::OP_SEARCH) begin
                        state_next = ibst_pkg::S_WALK;
                    end else if (s_op == ibst_pkg::OP_IN || s_op == ibst_pkg::OP_PRE
                                 || s_op == ibst_pkg::OP_POST) begin
                        state_next = valid_reg[0] ? ibst_pkg::S_TRAV : ibst_pkg::S_EMPTY;
                    end else begin
                        state_next = ibst_pkg::S_IDLE;
                    end
                end
            end
            ibst_pkg::S_WALK: begin
                if (walk_done && out_free) begin
                    state_next = ibst_pkg::S_IDLE;
                end
            end
            ibst_pkg::S_TRAV: begin
                priority if (sp_reg == '0) begin
                    state_next = ibst_pkg::S_FLUSH;
                end else if (top_ph == order_reg) begin
                    state_next = ibst_pkg::S_TRAV_EX;
                end else begin
                    state_next = ibst_pkg::S_TRAV;
                end
            end
            ibst_pkg::S_TRAV_EX: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = ibst_pkg::S_TRAV;
                end
            end
            ibst_pkg::S_FLUSH, ibst_pkg::S_EMPTY: begin
                if (out_free) begin
                    state_next = ibst_pkg::S_IDLE;
                end
            end
            default: state_next = ibst_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        op_next         = op_reg;
        order_next      = order_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        sp_next         = sp_reg;
        stk_idx_next    = stk_idx_reg;
        stk_ph_next     = stk_ph_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        valid_next      = valid_reg;
        rd_addr         = '0;
        mem_we          = 1'b0;

        unique case (state_reg)
            ibst_pkg::S_IDLE: begin
                if (s_accept) begin
                    op_next         = s_op;
                    key_next        = s_tdata[ibst_pkg::VALUE_BITS-1:0];
                    idx_next        = '0;
                    sp_next         = ibst_pkg::SP_W'(1);
                    stk_idx_next[0] = '0;
                    stk_ph_next[0]  = ibst_pkg::PH_PRE;
                    pend_valid_next = 1'b0;
                    priority if (s_op == ibst_pkg::OP_PRE) begin
                        order_next = ibst_pkg::PH_PRE;
                    end else if (s_op == ibst_pkg::OP_IN) begin
                        order_next = ibst_pkg::PH_IN;
                    end else begin
                        order_next = ibst_pkg::PH_POST;
                    end
                end
            end
            ibst_pkg::S_WALK: begin
                if (!walk_done) begin
                    idx_next = walk_child;
                    if (walk_child < ibst_pkg::WALK_W'(ibst_pkg::CAPACITY)) begin
                        rd_addr = walk_child[ibst_pkg::IDX_W-1:0];
                    end
                end else if (out_free) begin
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    out_last_next  = 1'b1;
                    if (op_reg == ibst_pkg::OP_INSERT) begin
                        if (idx_reg < ibst_pkg::WALK_W'(ibst_pkg::CAPACITY)) begin
                            mem_we          = 1'b1;
                            valid_next[idx_reg[ibst_pkg::IDX_W-1:0]] = 1'b1;
                            out_status_next = ibst_pkg::ST_INSERTED;
                        end else begin
                            out_status_next = ibst_pkg::ST_NO_ROOM;
                        end
                    end else begin
                        priority if (walk_in) begin
                            out_status_next = ibst_pkg::ST_FOUND;
                        end else if (idx_reg == '0) begin
                            out_status_next = ibst_pkg::ST_EMPTY;
                        end else begin
                            out_status_next = ibst_pkg::ST_NOT_FOUND;
                        end
                    end
                end else if (idx_reg < ibst_pkg::WALK_W'(ibst_pkg::CAPACITY)) begin
                    rd_addr = idx_reg[ibst_pkg::IDX_W-1:0];
                end
            end
            ibst_pkg::S_TRAV, ibst_pkg::S_TRAV_EX: begin
                rd_addr = top_idx;
                if ((state_reg == ibst_pkg::S_TRAV_EX && (!pend_valid_reg || out_free))
                    || (state_reg == ibst_pkg::S_TRAV && sp_reg != '0
                        && top_ph != order_reg)) begin
                    if (state_reg == ibst_pkg::S_TRAV_EX) begin
                        if (pend_valid_reg) begin
                            out_valid_next  = 1'b1;
                            out_status_next = ibst_pkg::ST_NODE;
                            out_value_next  = pend_value_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_value_next = rd_data_reg;
                    end
                    if (top_ph == ibst_pkg::PH_POST) begin
                        sp_next = sp_reg - ibst_pkg::SP_W'(1);
                    end else begin
                        stk_ph_next[top_pos] = ibst_pkg::phase_t'(top_ph + 2'd1);
                        if (trav_push) begin
                            stk_idx_next[sp_reg[ibst_pkg::STK_W-1:0]] =
                                trav_child[ibst_pkg::IDX_W-1:0];
                            stk_ph_next[sp_reg[ibst_pkg::STK_W-1:0]] = ibst_pkg::PH_PRE;
                            sp_next = sp_reg + ibst_pkg::SP_W'(1);
                        end
                    end
                end
            end
            ibst_pkg::S_FLUSH: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = ibst_pkg::ST_NODE;
                    out_value_next  = pend_value_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            ibst_pkg::S_EMPTY: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = ibst_pkg::ST_TRAV_EMPTY;
                    out_value_next  = '0;
                    out_last_next   = 1'b1;
                end
            end
            default: begin
                out_valid_next = out_valid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[idx_reg[ibst_pkg::IDX_W-1:0]] <= key_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ibst_pkg::S_IDLE;
            sp_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            valid_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            sp_reg         <= sp_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        order_reg      <= order_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        stk_idx_reg    <= stk_idx_next;
        stk_ph_reg     <= stk_ph_next;
        pend_value_reg <= pend_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ibst_pkg::DATA_W'(out_value_reg);
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hw/rtl/ibst_checker.sv
module ibst_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [ibst_pkg::OP_W-1:0]       s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ibst_pkg::DATA_W-1:0]     m_tdata,
    input logic [ibst_pkg::STATUS_W-1:0]   m_tuser,
    input logic                            m_tlast
);

    // a stalled result stays
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // only traversal nodes can be followed by more results of the same transaction
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ibst_pkg::ST_NODE |-> m_tlast)
        else $error("non-node status without tlast");

    a_single_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ibst_pkg::ST_NODE |-> m_tdata == '0)
        else $error("non-node status with nonzero value");

    // a defined op closes the input in the cycle after it is accepted
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser <= ibst_pkg::OP_POST |=> !s_tready)
        else $error("input open right after a transaction");

endmodule

bind implicit_array_bst_engine_core ibst_checker u_ibst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
